FILE: src/sdp_pkg.sv
// Shared types, constants and the arctangent table of the stick square-to-disc mapper.
package sdp_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CW = 34;                 // CORDIC datapath width
	localparam logic [6:0] AXIS_COUNT_RST = 7'd8;
	localparam logic [29:0] UNIT_SQ = 30'd1073676289;   // 32767 * 32767

	// atan(2^-i) in units of pi/2^31.
	localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic [4:0] stick_index;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
	} req_t;

	typedef struct packed {
		logic index_valid;
		logic signed [15:0] x_norm;
		logic signed [15:0] y_norm;
		logic signed [15:0] angle;
		logic [14:0] radius;
	} rsp_t;

	typedef struct packed {
		logic zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] acc;
	} cordic_t;

	typedef struct packed {
		logic inb;
		logic signed [15:0] xn;
		logic signed [15:0] yn;
	} side_t;

endpackage

FILE: src/sdp_sqrt_cell.sv
// One bit step of a restoring integer square root, registered.
module sdp_sqrt_cell #(
	parameter int RW = 15
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad_i,
	input  logic [RW+1:0]   rem_i,
	input  logic [RW-1:0]   root_i,
	output logic [2*RW-1:0] rad_o,
	output logic [RW+1:0]   rem_o,
	output logic [RW-1:0]   root_o
);

	logic [RW+3:0] cur;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          take;
	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;

	always_comb begin
		cur = {rem_i, rad_i[2*RW-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		diff = cur - trial;
		take = (cur >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= {rad_i[2*RW-3:0], 2'b00};
			rem_q <= take ? diff[RW+1:0] : cur[RW+1:0];
			root_q <= {root_i[RW-2:0], take};
		end
	end

	assign rad_o = rad_q;
	assign rem_o = rem_q;
	assign root_o = root_q;

endmodule

FILE: src/sdp_cordic_cell.sv
// One vectoring step of the CORDIC angle chain, registered.
module sdp_cordic_cell #(
	parameter int SHIFT = 0,
	parameter logic [31:0] ATAN = 32'd0
) (
	input  logic             clk,
	input  logic             en,
	input  sdp_pkg::cordic_t c_i,
	output sdp_pkg::cordic_t c_o
);

	logic signed [sdp_pkg::CW-1:0] dx;
	logic signed [sdp_pkg::CW-1:0] dy;
	logic signed [sdp_pkg::CW-1:0] step;
	logic                          pos;
	sdp_pkg::cordic_t              nxt;
	sdp_pkg::cordic_t              c_q;

	always_comb begin
		dx = c_i.y >>> SHIFT;
		dy = c_i.x >>> SHIFT;
		step = $signed({{(sdp_pkg::CW-32){1'b0}}, ATAN});
		pos = !c_i.y[sdp_pkg::CW-1] && (c_i.y != '0);
		nxt.zero = c_i.zero;
		if (pos) begin
			nxt.x = c_i.x + dx;
			nxt.y = c_i.y - dy;
			nxt.acc = c_i.acc + step;
		end else begin
			nxt.x = c_i.x - dx;
			nxt.y = c_i.y + dy;
			nxt.acc = c_i.acc - step;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= nxt;
		end
	end

	assign c_o = c_q;

endmodule

FILE: src/stick_square_to_disc_polar.sv
// Top level of the stick square-to-disc mapper with polar output.
// Fully pipelined: one request is taken per cycle, and the latency from an
// accepted request to its result does not depend on CORDIC_STEPS. The latency is
// set by the two square-root cell chains (15 cells for the disc scale factors,
// 31 cells for the radius) plus the multiply, square and sum stages between
// them; the angle chain of CORDIC_STEPS cells runs beside the radius path and
// is padded to the same length. The whole pipeline holds only while a result
// waits at the output and the consumer is not ready. axis_count is written
// through cfg_we/cfg_wdata and resets to 8.
module stick_square_to_disc_polar #(
	parameter int CORDIC_STEPS = sdp_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sdp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sdp_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata
);

	localparam int RW1 = 15;
	localparam int RW2 = 31;
	localparam int TAIL = RW2 + 2;               // stages after the product stage
	localparam int PAD = TAIL - CORDIC_STEPS - 2;
	localparam int NST = 3 + RW1 + TAIL;         // valid stages before the output

	logic       adv;
	logic [6:0] axis_count_q;
	logic [NST-1:0] vld_q;
	logic       rsp_valid_q;
	sdp_pkg::rsp_t rsp_q;

	assign adv = !rsp_valid_q || rsp_ready;
	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_count_q <= sdp_pkg::AXIS_COUNT_RST;
		end else if (cfg_we) begin
			axis_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], req_valid};
			rsp_valid_q <= vld_q[NST-1];
		end
	end

	// Stage 1: bounds check and normalization.
	sdp_pkg::side_t a_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1.inb <= ({1'b0, req.stick_index, 1'b1} < axis_count_q);
			a_s1.xn <= (req.raw_x == 16'sh8000) ? -16'sd32767 : req.raw_x;
			a_s1.yn <= (req.raw_y == 16'sh8000) ? 16'sd32767 : -req.raw_y;
		end
	end

	// Stage 2: radicands of the disc scale factors.
	logic signed [31:0] xsq;
	logic signed [31:0] ysq;
	logic [29:0] radx_s2;
	logic [29:0] rady_s2;
	sdp_pkg::side_t a_s2;
	assign xsq = a_s1.xn * a_s1.xn;
	assign ysq = a_s1.yn * a_s1.yn;
	always_ff @(posedge clk) begin
		if (adv) begin
			radx_s2 <= sdp_pkg::UNIT_SQ - xsq[30:1];
			rady_s2 <= sdp_pkg::UNIT_SQ - ysq[30:1];
			a_s2 <= a_s1;
		end
	end

	// Scale-factor square roots, two lanes.
	logic [2*RW1-1:0] qx_rad [RW1+1];
	logic [RW1+1:0]   qx_rem [RW1+1];
	logic [RW1-1:0]   qx_root [RW1+1];
	logic [2*RW1-1:0] qy_rad [RW1+1];
	logic [RW1+1:0]   qy_rem [RW1+1];
	logic [RW1-1:0]   qy_root [RW1+1];
	sdp_pkg::side_t   sa_q [RW1+1];

	assign qx_rad[0] = radx_s2;
	assign qx_rem[0] = '0;
	assign qx_root[0] = '0;
	assign qy_rad[0] = rady_s2;
	assign qy_rem[0] = '0;
	assign qy_root[0] = '0;
	assign sa_q[0] = a_s2;

	for (genvar k = 0; k < RW1; k++) begin : g_sq1
		sdp_sqrt_cell #(.RW(RW1)) u_cx (
			.clk(clk), .en(adv),
			.rad_i(qx_rad[k]), .rem_i(qx_rem[k]), .root_i(qx_root[k]),
			.rad_o(qx_rad[k+1]), .rem_o(qx_rem[k+1]), .root_o(qx_root[k+1])
		);
		sdp_sqrt_cell #(.RW(RW1)) u_cy (
			.clk(clk), .en(adv),
			.rad_i(qy_rad[k]), .rem_i(qy_rem[k]), .root_i(qy_root[k]),
			.rad_o(qy_rad[k+1]), .rem_o(qy_rem[k+1]), .root_o(qy_root[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				sa_q[k+1] <= sa_q[k];
			end
		end
	end

	// Product stage: mapped point, in units of 1/S^2.
	logic signed [31:0] mxp;
	logic signed [31:0] myp;
	logic signed [30:0] mx_s4;
	logic signed [30:0] my_s4;
	sdp_pkg::side_t a_s4;
	assign mxp = sa_q[RW1].xn * $signed({1'b0, qy_root[RW1]});
	assign myp = sa_q[RW1].yn * $signed({1'b0, qx_root[RW1]});
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s4 <= mxp[30:0];
			my_s4 <= myp[30:0];
			a_s4 <= sa_q[RW1];
		end
	end

	// Radius path: squares, sum, square root.
	logic [29:0] mxa;
	logic [29:0] mya;
	logic [59:0] mx2_s5;
	logic [59:0] my2_s5;
	logic [60:0] sum_s6;
	logic [30:0] mxn;
	logic [30:0] myn;
	assign mxn = mx_s4[30] ? -mx_s4 : mx_s4;
	assign myn = my_s4[30] ? -my_s4 : my_s4;
	assign mxa = mxn[29:0];
	assign mya = myn[29:0];
	always_ff @(posedge clk) begin
		if (adv) begin
			mx2_s5 <= mxa * mxa;
			my2_s5 <= mya * mya;
			sum_s6 <= {1'b0, mx2_s5} + {1'b0, my2_s5};
		end
	end

	logic [2*RW2-1:0] r_rad [RW2+1];
	logic [RW2+1:0]   r_rem [RW2+1];
	logic [RW2-1:0]   r_root [RW2+1];
	assign r_rad[0] = {1'b0, sum_s6};
	assign r_rem[0] = '0;
	assign r_root[0] = '0;

	for (genvar k = 0; k < RW2; k++) begin : g_sq2
		sdp_sqrt_cell #(.RW(RW2)) u_cr (
			.clk(clk), .en(adv),
			.rad_i(r_rad[k]), .rem_i(r_rem[k]), .root_i(r_root[k]),
			.rad_o(r_rad[k+1]), .rem_o(r_rem[k+1]), .root_o(r_root[k+1])
		);
	end

	// Side data waits beside the radius path.
	sdp_pkg::side_t sb_q [TAIL];
	always_ff @(posedge clk) begin
		if (adv) begin
			sb_q[0] <= a_s4;
			for (int k = 1; k < TAIL; k++) begin
				sb_q[k] <= sb_q[k-1];
			end
		end
	end

	// Angle path: quadrant pre-rotation, CORDIC cells, rounding, padding.
	sdp_pkg::cordic_t cpre_s5;
	sdp_pkg::cordic_t cpre;
	logic signed [sdp_pkg::CW-1:0] mxe;
	logic signed [sdp_pkg::CW-1:0] mye;
	always_comb begin
		mxe = {{(sdp_pkg::CW-31){mx_s4[30]}}, mx_s4};
		mye = {{(sdp_pkg::CW-31){my_s4[30]}}, my_s4};
		cpre.zero = (mx_s4 == '0) && (my_s4 == '0);
		cpre.x = mxe;
		cpre.y = mye;
		cpre.acc = '0;
		if (mx_s4[30]) begin
			if (!my_s4[30]) begin
				cpre.x = mye;
				cpre.y = -mxe;
				cpre.acc = 34'sd1073741824;
			end else begin
				cpre.x = -mye;
				cpre.y = mxe;
				cpre.acc = -34'sd1073741824;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cpre_s5 <= cpre;
		end
	end

	sdp_pkg::cordic_t cc [CORDIC_STEPS+1];
	assign cc[0] = cpre_s5;
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		sdp_cordic_cell #(.SHIFT(k), .ATAN(sdp_pkg::ATAN_TAB[k])) u_cc (
			.clk(clk), .en(adv), .c_i(cc[k]), .c_o(cc[k+1])
		);
	end

	logic signed [sdp_pkg::CW-1:0] acc_rnd;
	logic signed [15:0] ang_q [PAD+1];
	assign acc_rnd = cc[CORDIC_STEPS].acc + 34'sd32768;
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_q[0] <= cc[CORDIC_STEPS].zero ? 16'sd0 : acc_rnd[31:16];
			for (int k = 1; k <= PAD; k++) begin
				ang_q[k] <= ang_q[k-1];
			end
		end
	end

	// Output register: radius divided by 32767 with rounding, then assembly.
	logic [31:0] rv;
	logic [16:0] rt;
	logic [17:0] rc;
	logic [17:0] rq;
	logic [14:0] rad;
	sdp_pkg::side_t sfin;
	always_comb begin
		rv = {1'b0, r_root[RW2]} + 32'd16383;
		rt = rv[31:15];
		rc = {1'b0, rt} + {3'b000, rv[14:0]};
		if (rc >= 18'd65534) begin
			rq = {1'b0, rt} + 18'd2;
		end else if (rc >= 18'd32767) begin
			rq = {1'b0, rt} + 18'd1;
		end else begin
			rq = {1'b0, rt};
		end
		rad = (rq > 18'd32767) ? 15'd32767 : rq[14:0];
		sfin = sb_q[TAIL-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sfin.inb) begin
				rsp_q.index_valid <= 1'b1;
				rsp_q.x_norm <= sfin.xn;
				rsp_q.y_norm <= sfin.yn;
				rsp_q.angle <= ang_q[PAD];
				rsp_q.radius <= rad;
			end else begin
				rsp_q <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.index_valid |-> rsp.angle == '0 && rsp.radius == '0
			&& rsp.x_norm == '0 && rsp.y_norm == '0)
		else $error("out-of-range stick produced a nonzero result");

	a_norm_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.x_norm != 16'sh8000 && rsp.y_norm != 16'sh8000)
		else $error("normalized sample escaped saturation");

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("request ready does not follow the output stall");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule
